[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define UER_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: label");

// implication checked on every rising clock edge outside reset
`define UER_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
    else $error("assertion failed: label");

`endif

[rtl/uer_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// types, register map, zone codes and constants of the echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int CountWidth = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 3;
  localparam int DistW      = 10;
  localparam int ZoneW      = 3;
  localparam int LedW       = 4;

  // distance = count / 29, done as multiply by reciprocal and shift
  localparam int DivW       = 16;
  localparam int CmDivisor  = 29;
  localparam int RecipShift = 21;
  localparam int RecipW     = 17;
  localparam logic [RecipW-1:0] CmRecip =
    RecipW'((2 ** RecipShift + CmDivisor - 1) / CmDivisor);
  localparam logic [DistW-1:0] DistMax = '1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTriggerTicks  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWaitTimeout   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEchoTimeout   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxCount      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClearAbove    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCriticalBelow = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWarningBelow  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMediumBelow   = 3'd7;

  // register reset values
  localparam logic [7:0]       RstTriggerTicks  = 8'd5;
  localparam logic [15:0]      RstWaitTimeout   = 16'd30000;
  localparam logic [15:0]      RstEchoTimeout   = 16'd30000;
  localparam logic [15:0]      RstMaxCount      = 16'd20000;
  localparam logic [DistW-1:0] RstClearAbove    = 10'd200;
  localparam logic [DistW-1:0] RstCriticalBelow = 10'd15;
  localparam logic [DistW-1:0] RstWarningBelow  = 10'd30;
  localparam logic [DistW-1:0] RstMediumBelow   = 10'd50;

  // zone codes
  localparam logic [ZoneW-1:0] ZoneClear    = 3'd0;
  localparam logic [ZoneW-1:0] ZoneCritical = 3'd1;
  localparam logic [ZoneW-1:0] ZoneWarning  = 3'd2;
  localparam logic [ZoneW-1:0] ZoneMedium   = 3'd3;
  localparam logic [ZoneW-1:0] ZoneSafe     = 3'd4;

  // led patterns
  localparam logic [LedW-1:0] LedClear    = 4'h0;
  localparam logic [LedW-1:0] LedCritical = 4'h8;
  localparam logic [LedW-1:0] LedWarning  = 4'h4;
  localparam logic [LedW-1:0] LedMedium   = 4'h2;
  localparam logic [LedW-1:0] LedSafe     = 4'h1;

  typedef struct packed {
    logic [7:0]       trigger_ticks;
    logic [15:0]      wait_timeout;
    logic [15:0]      echo_timeout;
    logic [15:0]      max_count;
    logic [DistW-1:0] clear_above;
    logic [DistW-1:0] critical_below;
    logic [DistW-1:0] warning_below;
    logic [DistW-1:0] medium_below;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic             trigger;
    logic             done_res;
    logic [DistW-1:0] distance_cm;
    logic [ZoneW-1:0] zone;
    logic [LedW-1:0]  leds;
    logic             buzzer;
  } out_item_t;

  typedef struct packed {
    logic [ZoneW-1:0] zone;
    logic [LedW-1:0]  leds;
    logic             buzzer;
  } zone_res_t;

endpackage

[rtl/uer_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module uer_cfg_regs import uer_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks  <= RstTriggerTicks;
      cfg_q.wait_timeout   <= RstWaitTimeout;
      cfg_q.echo_timeout   <= RstEchoTimeout;
      cfg_q.max_count      <= RstMaxCount;
      cfg_q.clear_above    <= RstClearAbove;
      cfg_q.critical_below <= RstCriticalBelow;
      cfg_q.warning_below  <= RstWarningBelow;
      cfg_q.medium_below   <= RstMediumBelow;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTriggerTicks:  cfg_q.trigger_ticks  <= cfg_data_i[7:0];
        RegWaitTimeout:   cfg_q.wait_timeout   <= cfg_data_i[15:0];
        RegEchoTimeout:   cfg_q.echo_timeout   <= cfg_data_i[15:0];
        RegMaxCount:      cfg_q.max_count      <= cfg_data_i[15:0];
        RegClearAbove:    cfg_q.clear_above    <= cfg_data_i[DistW-1:0];
        RegCriticalBelow: cfg_q.critical_below <= cfg_data_i[DistW-1:0];
        RegWarningBelow:  cfg_q.warning_below  <= cfg_data_i[DistW-1:0];
        RegMediumBelow:   cfg_q.medium_below   <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/uer_zone.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_zone
// classifies a distance into a zone with its led pattern and buzzer bit
// ----------------------------------------------------------------------------
module uer_zone import uer_pkg::*; (
  input  logic [DistW-1:0] dist_i,
  input  cfg_t             cfg_i,
  output zone_res_t        res_o
);

  always_comb begin
    res_o.buzzer = 1'b0;
    if (dist_i == '0 || dist_i > cfg_i.clear_above) begin
      res_o.zone = ZoneClear;
      res_o.leds = LedClear;
    end else if (dist_i < cfg_i.critical_below) begin
      res_o.zone   = ZoneCritical;
      res_o.leds   = LedCritical;
      res_o.buzzer = 1'b1;
    end else if (dist_i < cfg_i.warning_below) begin
      res_o.zone = ZoneWarning;
      res_o.leds = LedWarning;
    end else if (dist_i < cfg_i.medium_below) begin
      res_o.zone = ZoneMedium;
      res_o.leds = LedMedium;
    end else begin
      res_o.zone = ZoneSafe;
      res_o.leds = LedSafe;
    end
  end

endmodule

[rtl/uer_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_seq
// measurement sequencer: trigger, wait for echo, count echo, report
// ----------------------------------------------------------------------------
module uer_seq import uer_pkg::*; #(
  parameter int CountWidth = uer_pkg::CountWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTrig = 2'd1;
  localparam logic [1:0] PhWait = 2'd2;
  localparam logic [1:0] PhMeas = 2'd3;

  localparam int CmpW = (CountWidth > 16) ? CountWidth : 16;
  localparam int MulW = DivW + RecipW;
  localparam int QuoW = MulW - RecipShift;
  localparam logic [CountWidth-1:0] CntTop = '1;

  logic [1:0]            phase_q, phase_d;
  logic [CountWidth-1:0] guard_q, guard_d;
  logic [CountWidth-1:0] pulse_q, pulse_d;
  logic [LedW-1:0]       leds_q, leds_d;
  logic                  buzzer_q, buzzer_d;

  logic [CountWidth-1:0] guard_dec, guard_inc, pulse_inc;
  logic [DivW-1:0]       dividend;
  logic [MulW-1:0]       product;
  logic [QuoW-1:0]       quotient;
  logic [DistW-1:0]      meas_dist;
  logic                  trig;
  logic                  fin;
  logic [DistW-1:0]      fin_dist;
  zone_res_t             zres;

  // divide by 29 via reciprocal multiply, saturate to the distance range
  assign dividend  = DivW'(pulse_q);
  assign product   = MulW'(dividend) * MulW'(CmRecip);
  assign quotient  = product[MulW-1:RecipShift];
  assign meas_dist = (quotient > QuoW'(DistMax)) ? DistMax : quotient[DistW-1:0];

  assign guard_dec = (guard_q != '0) ? guard_q - 1'b1 : guard_q;
  assign guard_inc = (guard_q != CntTop) ? guard_q + 1'b1 : guard_q;
  assign pulse_inc = (pulse_q != CntTop) ? pulse_q + 1'b1 : pulse_q;

  always_comb begin
    phase_d  = phase_q;
    guard_d  = guard_q;
    pulse_d  = pulse_q;
    trig     = 1'b0;
    fin      = 1'b0;
    fin_dist = '0;
    unique case (phase_q)
      PhIdle: begin
        if (item_i.start_req) begin
          trig    = 1'b1;
          pulse_d = '0;
          if (cfg_i.trigger_ticks <= 8'd1) begin
            phase_d = PhWait;
            guard_d = '0;
          end else begin
            phase_d = PhTrig;
            guard_d = CountWidth'(cfg_i.trigger_ticks) - 1'b1;
          end
        end
      end
      PhTrig: begin
        trig    = 1'b1;
        guard_d = guard_dec;
        if (guard_dec == '0) begin
          phase_d = PhWait;
        end
      end
      PhWait: begin
        if (item_i.echo) begin
          phase_d = PhMeas;
          pulse_d = CountWidth'(1);
          if (cfg_i.echo_timeout <= 16'd1) begin
            fin = 1'b1;
          end
        end else begin
          guard_d = guard_inc;
          if (CmpW'(guard_inc) >= CmpW'(cfg_i.wait_timeout) || guard_inc == CntTop) begin
            fin = 1'b1;
          end
        end
      end
      PhMeas: begin
        if (item_i.echo) begin
          pulse_d = pulse_inc;
          if (CmpW'(pulse_inc) >= CmpW'(cfg_i.echo_timeout) || pulse_inc == CntTop) begin
            fin = 1'b1;
          end
        end else if (CmpW'(pulse_q) > CmpW'(cfg_i.max_count)) begin
          fin = 1'b1;
        end else begin
          fin      = 1'b1;
          fin_dist = meas_dist;
        end
      end
      default: ;
    endcase
    if (fin) begin
      phase_d = PhIdle;
      guard_d = '0;
      pulse_d = '0;
    end
  end

  uer_zone u_zone (
    .dist_i (fin_dist),
    .cfg_i  (cfg_i),
    .res_o  (zres)
  );

  assign leds_d   = fin ? zres.leds : leds_q;
  assign buzzer_d = fin ? zres.buzzer : buzzer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      guard_q  <= '0;
      pulse_q  <= '0;
      leds_q   <= '0;
      buzzer_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      guard_q  <= guard_d;
      pulse_q  <= pulse_d;
      leds_q   <= leds_d;
      buzzer_q <= buzzer_d;
    end
  end

  always_comb begin
    res_o.trigger     = trig;
    res_o.done_res    = fin;
    res_o.distance_cm = fin_dist;
    res_o.zone        = fin ? zres.zone : ZoneClear;
    res_o.leds        = leds_d;
    res_o.buzzer      = buzzer_d;
  end

endmodule

[rtl/ultrasonic_echo_ranger_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// tick driven ultrasonic echo ranger with zone, led and buzzer outputs
// ----------------------------------------------------------------------------
// usage:
//   each input item is one timer tick carrying start_req and the sampled echo
//   level; every item gives exactly one result item with the trigger level,
//   the done flag, distance, zone, leds and buzzer for that tick
//   in_valid_i / in_stall_o and out_valid_o / out_stall_i move items; an item
//   moves on an edge where valid is high and stall is low
//   a result item passes through the input register, then the result register,
//   and leaves on an edge where out_stall_i is low; one item per cycle is
//   sustained while the receiver does not stall, since the sequencer updates
//   once per tick
//   when the receiver stalls, the result register holds; the input register
//   takes at most one more item and in_stall_o stays high until the result
//   is taken
//   configuration is written on any edge with cfg_we_i high, meant for idle
//   reset clears the sequencer to idle, the counters and the last led and
//   buzzer values, and loads the default register values
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top import uer_pkg::*; #(
  parameter int CountWidth = uer_pkg::CountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, res;
  logic      out_valid_q;
  logic      step;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  uer_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  uer_seq #(
    .CountWidth (CountWidth)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/uer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_checker
// port level checks of the echo ranger result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uer_checker import uer_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `UER_ASSERT_IMP(a_idle_fields, clk_i, rst_ni, out_valid_o && !out_item_o.done_res, out_item_o.distance_cm == '0 && out_item_o.zone == ZoneClear)
  `UER_ASSERT_IMP(a_buzzer_zone, clk_i, rst_ni, out_valid_o && out_item_o.done_res, out_item_o.buzzer == (out_item_o.zone == ZoneCritical))
  `UER_ASSERT_IMP(a_leds_onehot, clk_i, rst_ni, out_valid_o, $onehot0(out_item_o.leds) && out_item_o.buzzer == out_item_o.leds[3])
  `UER_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 out_valid_o && $stable(out_item_o))

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
